// ===== rtl/wbps_pkg.sv =====
// -----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern search.
// -----------------------------------------------------------------------------
package wbps_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int PAT_BYTES   = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int COUNT_W     = 32;
	localparam int LEN_W       = 5;
	localparam int MASK_W      = 16;
	localparam int BYTE_W      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MASK  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              region_start;
	} item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pattern_low;
		logic [CFG_DATA_W-1:0] pattern_high;
		logic [MASK_W-1:0]     wildcard_mask;
		logic [LEN_W-1:0]      pattern_length;
	} cfg_t;

	typedef struct packed {
		logic               hit;
		logic [COUNT_W-1:0] match_offset;
	} result_t;

endpackage

// ===== rtl/wbps_if.sv =====
// -----------------------------------------------------------------------------
// wbps_in_if / wbps_out_if
// Valid/ready channels for the byte stream and the match offsets.
// -----------------------------------------------------------------------------
interface wbps_in_if;
	logic                         valid;
	logic                         ready;
	logic [wbps_pkg::BYTE_W-1:0]  data_byte;
	logic                         region_start;

	modport source (output valid, output data_byte, output region_start, input ready);
	modport sink (input valid, input data_byte, input region_start, output ready);
endinterface

interface wbps_out_if;
	logic                         valid;
	logic                         ready;
	logic [wbps_pkg::COUNT_W-1:0] match_offset;

	modport source (output valid, output match_offset, input ready);
	modport sink (input valid, input match_offset, output ready);
endinterface

// ===== rtl/wbps_cfg.sv =====
// -----------------------------------------------------------------------------
// wbps_cfg
// Configuration register file: pattern, wildcard mask and pattern length.
// -----------------------------------------------------------------------------
module wbps_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data,
	output wbps_pkg::cfg_t                     cfg
);

	wbps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.wildcard_mask  <= '0;
			cfg_q.pattern_length <= wbps_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				wbps_pkg::REG_PATTERN_LOW: begin
					cfg_q.pattern_low <= cfg_data;
				end
				wbps_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pattern_high <= cfg_data;
				end
				wbps_pkg::REG_WILDCARD_MASK: begin
					cfg_q.wildcard_mask <= cfg_data[wbps_pkg::MASK_W-1:0];
				end
				wbps_pkg::REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[wbps_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/wbps_core.sv =====
// -----------------------------------------------------------------------------
// wbps_core
// Byte window, region counters and the parallel masked compare.
// -----------------------------------------------------------------------------
module wbps_core #(
	parameter int MaxPattern = wbps_pkg::MAX_PATTERN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  wbps_pkg::item_t   item,
	input  wbps_pkg::cfg_t    cfg,
	output wbps_pkg::result_t res
);

	localparam int LenW = ($clog2(MaxPattern + 1) > wbps_pkg::LEN_W) ?
		$clog2(MaxPattern + 1) : wbps_pkg::LEN_W;

	logic [wbps_pkg::BYTE_W-1:0]       win_q [MaxPattern];
	logic [wbps_pkg::BYTE_W-1:0]       win_n [MaxPattern];
	logic [wbps_pkg::COUNT_W-1:0]      seen_q;
	logic [wbps_pkg::COUNT_W-1:0]      blocked_q;
	logic [wbps_pkg::COUNT_W-1:0]      seen_base;
	logic [wbps_pkg::COUNT_W-1:0]      seen_n;
	logic [wbps_pkg::COUNT_W-1:0]      blocked_base;
	logic [wbps_pkg::COUNT_W-1:0]      blocked_n;
	logic [wbps_pkg::COUNT_W-1:0]      first;
	logic [LenW-1:0]                   len_raw;
	logic [LenW-1:0]                   eff_len;
	logic [wbps_pkg::PAT_BYTES*wbps_pkg::BYTE_W-1:0] pat;
	logic [MaxPattern-1:0]             pos_ok;
	logic                              counted;
	logic                              hit;

	assign len_raw = LenW'(cfg.pattern_length);
	assign pat     = {cfg.pattern_high, cfg.pattern_low};

	always_comb begin
		eff_len = len_raw;
		if (len_raw == '0) begin
			eff_len = LenW'(1);
		end
		if (eff_len > LenW'(MaxPattern)) begin
			eff_len = LenW'(MaxPattern);
		end
	end

	always_comb begin
		win_n[0] = item.data_byte;
		for (int k = 1; k < MaxPattern; k++) begin
			win_n[k] = win_q[k-1];
		end
	end

	for (genvar gi = 0; gi < MaxPattern; gi++) begin : g_pos
		if (gi < wbps_pkg::PAT_BYTES) begin : g_cmp
			logic [wbps_pkg::BYTE_W-1:0] cand;

			always_comb begin
				cand = '0;
				for (int k = 0; k < MaxPattern; k++) begin
					if (int'(eff_len) - 1 - gi == k) begin
						cand = win_n[k];
					end
				end
			end

			assign pos_ok[gi] = (gi >= int'(eff_len)) || cfg.wildcard_mask[gi] ||
				(cand == pat[gi*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W]);
		end else begin : g_wild
			assign pos_ok[gi] = 1'b1;
		end
	end

	always_comb begin
		seen_base    = item.region_start ? '0 : seen_q;
		blocked_base = item.region_start ? '0 : blocked_q;
		counted      = (seen_base != '1);
		seen_n       = counted ? seen_base + wbps_pkg::COUNT_W'(1) : seen_base;
		first        = seen_n - wbps_pkg::COUNT_W'(eff_len);
		hit          = counted && (seen_n >= wbps_pkg::COUNT_W'(eff_len)) &&
			(first >= blocked_base) && (&pos_ok);
		blocked_n    = blocked_base;
		if (hit) begin
			blocked_n = (seen_n == '1) ? seen_n : seen_n + wbps_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			blocked_q <= '0;
		end else if (adv) begin
			seen_q    <= seen_n;
			blocked_q <= blocked_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < MaxPattern; k++) begin
				win_q[k] <= win_n[k];
			end
		end
	end

	assign res.hit          = hit;
	assign res.match_offset = first;

endmodule

// ===== rtl/wildcard_byte_pattern_search_top.sv =====
// An accepted byte is held in the item_s1 register, compared, and its match offset is registered at the output.
// Throughput: one byte per cycle while the result channel takes each request.
// The compare of the whole window against the pattern is one parallel stage.
// Reset clears the counters, the pipeline valid flags and the configuration;
// the pattern length returns to one.
// -----------------------------------------------------------------------------
// wildcard_byte_pattern_search_top
// Streams region bytes through a window and reports wildcard pattern matches.
// -----------------------------------------------------------------------------
module wildcard_byte_pattern_search_top #(
	parameter int MaxPattern = wbps_pkg::MAX_PATTERN
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data,
	wbps_in_if.sink                         in_ch,
	wbps_out_if.source                      out_ch
);

	wbps_pkg::cfg_t               cfg;
	wbps_pkg::item_t              item_s1;
	wbps_pkg::result_t            res;
	logic                         valid_s1;
	logic                         out_valid_q;
	logic [wbps_pkg::COUNT_W-1:0] out_offset_q;
	logic                         adv;

	assign adv         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	wbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wbps_core #(
		.MaxPattern (MaxPattern)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.data_byte    <= in_ch.data_byte;
			item_s1.region_start <= in_ch.region_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.hit;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.hit) begin
			out_offset_q <= res.match_offset;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.match_offset = out_offset_q;

endmodule

// ===== rtl/wbps_checker.sv =====
// -----------------------------------------------------------------------------
// wbps_checker
// Port-level checks of the pattern search, bound to the top level.
// -----------------------------------------------------------------------------
module wbps_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [wbps_pkg::COUNT_W-1:0] out_offset
);

	// A stalled result request keeps its offset.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_offset))
		else $error("result request changed while stalled");

	// The input side is held off only by a stalled result.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	// With nothing in flight, no result request can appear.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(in_valid && in_ready) |=> !out_valid)
		else $error("result request without a pending byte");

	// Leaving reset, no result request is pending.
	a_reset_clear: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result request pending after reset");

endmodule

bind wildcard_byte_pattern_search_top wbps_checker u_wbps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_offset (out_ch.match_offset)
);
